[rtl/hight_block_decrypt_macros.svh]
// Assertion macros for the HIGHT decryption block.
`ifndef HIGHT_BLOCK_DECRYPT_MACROS_SVH
`define HIGHT_BLOCK_DECRYPT_MACROS_SVH

`ifndef SYNTHESIS
`define HBD_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define HBD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HBD_ASSERT(lbl, ante, cons)
`define HBD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/hbd_pkg.sv]
// Shared types, constants and round functions for the HIGHT decryption block.
package hbd_pkg;

	localparam int NUM_WK   = 8;
	localparam int NUM_SK   = 128;
	localparam int SK_LANES = 4;
	localparam int SK_ROWS  = NUM_SK / SK_LANES;
	localparam int ROW_W    = $clog2(SK_ROWS);
	localparam int LANE_W   = $clog2(SK_LANES);

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SK_ROWS - 1);
	localparam logic [ROW_W-1:0] ROW_FIRST = '0;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_DECRYPT = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_ROUND
	} hbd_state_t;

	typedef struct packed {
		logic             wr_en;
		logic             ld_x;
		logic             rd_en;
		logic [ROW_W-1:0] rd_row;
		logic             round_en;
		logic             no_rot;
		logic             fin;
	} hbd_cmd_t;

	function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
		rotl8 = (x << n) | (x >> (8 - n));
	endfunction

	function automatic logic [7:0] hf0(input logic [7:0] x);
		hf0 = rotl8(x, 1) ^ rotl8(x, 2) ^ rotl8(x, 7);
	endfunction

	function automatic logic [7:0] hf1(input logic [7:0] x);
		hf1 = rotl8(x, 3) ^ rotl8(x, 4) ^ rotl8(x, 6);
	endfunction

endpackage

[rtl/hbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/hbd_ctrl.sv]
// Controller: command handshake, round counter and sequencing state machine.
`include "hight_block_decrypt_macros.svh"
module hbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              action,
	output logic              busy,
	output hbd_pkg::hbd_cmd_t cmd
);
	import hbd_pkg::*;

	hbd_state_t       state_q, state_d;
	logic [ROW_W-1:0] cnt_q;
	logic             accept;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (action == ACT_DECRYPT)) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (cnt_q == ROW_FIRST) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy         = 1'b0;
		cmd          = '0;
		cmd.rd_row   = ROW_LAST;
		case (state_q)
			ST_IDLE: begin
				cmd.wr_en = accept && (action == ACT_LOAD);
				cmd.ld_x  = accept && (action == ACT_DECRYPT);
				cmd.rd_en = accept && (action == ACT_DECRYPT);
			end
			ST_ROUND: begin
				busy         = 1'b1;
				cmd.round_en = 1'b1;
				cmd.no_rot   = (cnt_q == ROW_LAST);
				cmd.fin      = (cnt_q == ROW_FIRST);
				cmd.rd_en    = (cnt_q != ROW_FIRST);
				cmd.rd_row   = cnt_q - 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_x) begin
				cnt_q <= ROW_LAST;
			end else if (cmd.round_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`HBD_ASSERT_NXT(a_start_round, start && !busy && (action == ACT_DECRYPT), busy && cnt_q == ROW_LAST)
	`HBD_ASSERT_NXT(a_round_holds, busy && cnt_q != ROW_FIRST, busy)
	`HBD_ASSERT_NXT(a_round_ends, busy && cnt_q == ROW_FIRST, !busy)
	`HBD_ASSERT(a_no_load_busy, busy, !cmd.wr_en && !cmd.ld_x)

endmodule

[rtl/hbd_datapath.sv]
// Datapath: key table, block state register and one decryption round a cycle.
module hbd_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  hbd_pkg::hbd_cmd_t cmd,
	input  logic [7:0]        key_index,
	input  logic [7:0]        key_byte,
	input  logic [63:0]       ciphertext,
	output logic [63:0]       plaintext,
	output logic              done
);
	import hbd_pkg::*;

	logic [7:0]       wk_q [NUM_WK];
	logic [7:0]       x_q  [8];
	logic [7:0]       xin  [8];
	logic [7:0]       y    [8];
	logic [7:0]       k    [SK_LANES];
	logic [7:0]       sk_idx;
	logic             sk_hit;
	logic [63:0]      pt;
	logic [63:0]      plaintext_q;
	logic             done_q;

	assign sk_idx = key_index - 8'(NUM_WK);
	assign sk_hit = (key_index >= 8'(NUM_WK)) && (key_index < 8'(NUM_WK + NUM_SK));

	for (genvar g = 0; g < SK_LANES; g++) begin : g_lane
		hbd_ram #(
			.WIDTH(8),
			.DEPTH(SK_ROWS)
		) u_sk_ram (
			.clk   (clk),
			.we    (cmd.wr_en && sk_hit && (sk_idx[LANE_W-1:0] == LANE_W'(g))),
			.waddr (sk_idx[LANE_W +: ROW_W]),
			.wdata (key_byte),
			.re    (cmd.rd_en),
			.raddr (cmd.rd_row),
			.rdata (k[g])
		);
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && (key_index < 8'(NUM_WK))) begin
			wk_q[key_index[2:0]] <= key_byte;
		end
	end

	// final whitening removed on entry
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			xin[j] = ciphertext[8*j +: 8];
		end
		xin[0] = xin[0] - wk_q[4];
		xin[2] = xin[2] ^ wk_q[5];
		xin[4] = xin[4] - wk_q[6];
		xin[6] = xin[6] ^ wk_q[7];
	end

	always_comb begin
		if (cmd.no_rot) begin
			y[0] = x_q[0];
			y[1] = x_q[1] - (hf1(x_q[0]) ^ k[0]);
			y[2] = x_q[2];
			y[3] = x_q[3] ^ (hf0(x_q[2]) + k[1]);
			y[4] = x_q[4];
			y[5] = x_q[5] - (hf1(x_q[4]) ^ k[2]);
			y[6] = x_q[6];
			y[7] = x_q[7] ^ (hf0(x_q[6]) + k[3]);
		end else begin
			y[0] = x_q[1];
			y[1] = x_q[2] - (hf1(x_q[1]) ^ k[0]);
			y[2] = x_q[3];
			y[3] = x_q[4] ^ (hf0(x_q[3]) + k[1]);
			y[4] = x_q[5];
			y[5] = x_q[6] - (hf1(x_q[5]) ^ k[2]);
			y[6] = x_q[7];
			y[7] = x_q[0] ^ (hf0(x_q[7]) + k[3]);
		end
	end

	// initial whitening removed on exit
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			pt[8*j +: 8] = y[j];
		end
		pt[7:0]   = y[0] - wk_q[0];
		pt[23:16] = y[2] ^ wk_q[1];
		pt[39:32] = y[4] - wk_q[2];
		pt[55:48] = y[6] ^ wk_q[3];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_x) begin
			x_q <= xin;
		end else if (cmd.round_en) begin
			x_q <= y;
		end
		if (cmd.fin) begin
			plaintext_q <= pt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin;
		end
	end

	assign plaintext = plaintext_q;
	assign done      = done_q;

endmodule

[rtl/hight_block_decrypt.sv]
// HIGHT-64/128 block decryption with a byte-loaded key table.
// A beat is taken when start is high and busy is low. A load beat (action 0) writes one
// key table byte in that cycle and leaves busy low, so loads may follow every cycle. A
// decrypt beat (action 1) raises busy while it runs one round a cycle, with each round's
// four subkeys read in the cycle before from a four-lane subkey RAM; plaintext is then
// shown with done for exactly one cycle. The receiver cannot stall: take plaintext
// whenever done is high. A new start is accepted in that cycle.
// Every key table entry that a decrypt uses must have been loaded since reset.
module hight_block_decrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [7:0]  key_index,
	input  logic [7:0]  key_byte,
	input  logic [63:0] ciphertext,
	output logic [63:0] plaintext,
	output logic        done
);
	import hbd_pkg::*;

	hbd_cmd_t cmd;

	hbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.busy   (busy),
		.cmd    (cmd)
	);

	hbd_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.key_index  (key_index),
		.key_byte   (key_byte),
		.ciphertext (ciphertext),
		.plaintext  (plaintext),
		.done       (done)
	);

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the HIGHT block decryption unit.
`timescale 1ns / 1ps

module tb;
	import hbd_pkg::*;

	localparam int TABLE_LEN  = hbd_pkg::NUM_WK + hbd_pkg::NUM_SK;
	localparam int RAND_BEATS = 170;

	localparam int FILL_ZERO = 0;
	localparam int FILL_ONES = 1;
	localparam int FILL_RAND = 2;

	class plaintext_tracker;
		logic [7:0]  wk[hbd_pkg::NUM_WK];
		logic [7:0]  sk[hbd_pkg::NUM_SK];
		logic [63:0] expected_plain[$];
		int          mismatches;
		int          strays;

		function logic [7:0] rot8(input logic [7:0] x, input int n);
			logic [15:0] d;
			d = {x, x} << n;
			return d[15:8];
		endfunction

		function logic [7:0] mix0(input logic [7:0] x);
			return rot8(x, 1) ^ rot8(x, 2) ^ rot8(x, 7);
		endfunction

		function logic [7:0] mix1(input logic [7:0] x);
			return rot8(x, 3) ^ rot8(x, 4) ^ rot8(x, 6);
		endfunction

		function logic [63:0] hight_decipher(input logic [63:0] ct);
			logic [7:0]  x[8];
			logic [7:0]  y[8];
			logic [63:0] pt;
			int          b;
			for (int j = 0; j < 8; j++) x[j] = ct[8*j +: 8];
			x[0] = x[0] - wk[4];
			x[2] = x[2] ^ wk[5];
			x[4] = x[4] - wk[6];
			x[6] = x[6] ^ wk[7];
			// last round carries no byte rotation
			x[1] = x[1] - (mix1(x[0]) ^ sk[124]);
			x[3] = x[3] ^ (mix0(x[2]) + sk[125]);
			x[5] = x[5] - (mix1(x[4]) ^ sk[126]);
			x[7] = x[7] ^ (mix0(x[6]) + sk[127]);
			for (int r = 30; r >= 0; r--) begin
				b = 4 * r;
				y[0] = x[1];
				y[1] = x[2] - (mix1(x[1]) ^ sk[b]);
				y[2] = x[3];
				y[3] = x[4] ^ (mix0(x[3]) + sk[b+1]);
				y[4] = x[5];
				y[5] = x[6] - (mix1(x[5]) ^ sk[b+2]);
				y[6] = x[7];
				y[7] = x[0] ^ (mix0(x[7]) + sk[b+3]);
				x = y;
			end
			x[0] = x[0] - wk[0];
			x[2] = x[2] ^ wk[1];
			x[4] = x[4] - wk[2];
			x[6] = x[6] ^ wk[3];
			for (int j = 0; j < 8; j++) pt[8*j +: 8] = x[j];
			return pt;
		endfunction

		function void note_beat(input logic act, input logic [7:0] idx, input logic [7:0] kb,
				input logic [63:0] ct);
			if (act == ACT_LOAD) begin
				if (idx < hbd_pkg::NUM_WK)
					wk[idx] = kb;
				else if (idx < TABLE_LEN)
					sk[idx - hbd_pkg::NUM_WK] = kb;
			end else begin
				expected_plain.push_back(hight_decipher(ct));
			end
		endfunction

		function void check_plaintext(input logic [63:0] got);
			logic [63:0] want;
			if (expected_plain.size() == 0) begin
				strays++;
				$display("unexpected plaintext %h", got);
			end else begin
				want = expected_plain.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("plaintext mismatch: expected %h got %h", want, got);
				end
			end
		endfunction

		function int pending();
			return expected_plain.size();
		endfunction

		function int failures();
			return mismatches + strays + expected_plain.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        action = ACT_LOAD;
	logic [7:0]  key_index = '0;
	logic [7:0]  key_byte = '0;
	logic [63:0] ciphertext = '0;
	logic        busy;
	logic [63:0] plaintext;
	logic        done;

	plaintext_tracker tracker = new;
	int calm_left = 0;

	hight_block_decrypt DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.key_index  (key_index),
		.key_byte   (key_byte),
		.ciphertext (ciphertext),
		.plaintext  (plaintext),
		.done       (done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_plaintext(plaintext);
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_beat(input logic act, input logic [7:0] idx, input logic [7:0] kb,
			input logic [63:0] ct);
		start      = 1'b1;
		action     = act;
		key_index  = idx;
		key_byte   = kb;
		ciphertext = ct;
		do @(posedge clk); while (busy);
		tracker.note_beat(act, idx, kb, ct);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int roll;
		int n;
		if (calm_left > 0) begin
			calm_left--;
			return;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			calm_left = $urandom_range(10, 40);
			n = 0;
		end else if (roll < 65)
			n = 0;
		else if (roll < 93)
			n = $urandom_range(1, 4);
		else
			n = $urandom_range(10, 60);
		if (n > 0) begin
			start = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic logic [63:0] rand_block();
		return {$urandom, $urandom};
	endfunction

	task automatic fill_table(input int mode);
		logic [7:0] kb;
		for (int i = 0; i < TABLE_LEN; i++) begin
			case (mode)
				FILL_ZERO: kb = 8'h00;
				FILL_ONES: kb = 8'hff;
				default:   kb = 8'($urandom_range(0, 255));
			endcase
			send_beat(ACT_LOAD, i[7:0], kb, rand_block());
			idle_gap();
		end
	endtask

	task automatic decrypt_beat(input logic [63:0] ct);
		send_beat(ACT_DECRYPT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), ct);
		idle_gap();
	endtask

	task automatic load_beat(input logic [7:0] idx, input logic [7:0] kb);
		send_beat(ACT_LOAD, idx, kb, rand_block());
		idle_gap();
	endtask

	initial begin
		int roll;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// whole table first, so no decrypt ever reads an unwritten entry
		fill_table(FILL_ZERO);
		decrypt_beat(64'h0);
		decrypt_beat({64{1'b1}});
		fill_table(FILL_ONES);
		decrypt_beat(64'h0);
		decrypt_beat({64{1'b1}});
		fill_table(FILL_RAND);
		decrypt_beat(64'h0);
		decrypt_beat({64{1'b1}});
		decrypt_beat(64'h0123_4567_89ab_cdef);
		decrypt_beat(64'h5555_5555_5555_5555);
		decrypt_beat(64'haaaa_aaaa_aaaa_aaaa);
		load_beat(8'd136, 8'h5a);
		load_beat(8'd255, 8'ha5);
		decrypt_beat(64'h0123_4567_89ab_cdef);
		load_beat(8'd0, 8'h00);
		load_beat(8'd7, 8'hff);
		load_beat(8'd8, 8'hff);
		load_beat(8'd135, 8'h00);
		decrypt_beat(rand_block());
		decrypt_beat(rand_block());

		for (int i = 0; i < RAND_BEATS; i++) begin
			roll = $urandom_range(0, 199);
			if (roll < 10)
				decrypt_beat($urandom_range(0, 1) ? 64'h0 : {64{1'b1}});
			else if (roll < 120)
				decrypt_beat(rand_block());
			else if (roll < 185)
				load_beat(8'($urandom_range(0, TABLE_LEN - 1)), 8'($urandom_range(0, 255)));
			else
				load_beat(8'($urandom_range(TABLE_LEN, 255)), 8'($urandom_range(0, 255)));
		end

		start = 1'b0;
		while (tracker.pending() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (tracker.failures() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
